// File: hw/rtl/aes128_ctr_stream_cipher_defines.svh
// assertion macros for the aes128 counter mode cipher
`ifndef AES128_CTR_STREAM_CIPHER_DEFINES_SVH
`define AES128_CTR_STREAM_CIPHER_DEFINES_SVH

// condition in this cycle implies expectation in this cycle
`define AESC_ASSERT_NOW(label, cond, exp_cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (exp_cond)) \
        else $error("assertion failed");

// condition in this cycle implies expectation in the next cycle
`define AESC_ASSERT_NEXT(label, cond, exp_cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (exp_cond)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/aesc_pkg.sv
// shared types, tables and round functions of the aes128 counter mode cipher
package aesc_pkg;

    localparam int ROUNDS = 10;
    localparam logic [4:0] FULL_BYTES = 5'd16;

    typedef struct packed {
        logic [127:0] state;
        logic [127:0] round_key;
        logic [127:0] text;
        logic [4:0]   nbytes;
    } stage_t;

    localparam logic [7:0] RCON [ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // byte 0 sits in the top bits
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                t[127 - 8 * (r + 4 * c) -: 8] = SBOX[s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3, x;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            x = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32 * c -: 8] = a0 ^ x ^ xtime(a0 ^ a1);
            t[119 - 32 * c -: 8] = a1 ^ x ^ xtime(a1 ^ a2);
            t[111 - 32 * c -: 8] = a2 ^ x ^ xtime(a2 ^ a3);
            t[103 - 32 * c -: 8] = a3 ^ x ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

    function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] tw, w0, w1, w2, w3;
        tw = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
        w0 = k[127:96] ^ tw;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// File: hw/rtl/aesc_round_cell.sv
// one aes round with its round key step, registered
module aesc_round_cell
    import aesc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic [7:0] rcon,
    input  logic       last_round,
    input  logic       valid_in,
    input  stage_t     data_in,
    output logic       valid_out,
    output stage_t     data_out
);

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;
    logic [127:0] sub_state;
    logic [127:0] key_next;

    always_comb
    begin
        key_next = next_key(data_in.round_key, rcon);
        sub_state = sub_shift(data_in.state);
        data_next = data_in;
        data_next.round_key = key_next;
        data_next.state = (last_round ? sub_state : mix_columns(sub_state)) ^ key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out = data_reg;

endmodule

// File: hw/rtl/aes128_ctr_stream_cipher.sv
// aes128 counter mode stream cipher top level
// pipeline: one load stage, ten round cells and the output register
// throughput: one 16-byte block per cycle while the output is not stalled; the ten
// round cells advance together, and a stalled output holds the whole row of cells
// reset clears valid bits, counter and configuration registers to zero
`include "aes128_ctr_stream_cipher_defines.svh"
module aes128_ctr_stream_cipher
    import aesc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // text_high, text_low, byte_count
    input  logic         s_axis_tuser,  // first_block
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata   // cipher_high, cipher_low, valid_bytes
);

    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [1:0] REG_CTR_HIGH = 2'd2;
    localparam logic [1:0] REG_CTR_LOW  = 2'd3;

    logic [63:0] key_high_reg, key_low_reg, init_ctr_high_reg, init_ctr_low_reg;
    logic [63:0] ctr_upper_reg, ctr_lower_reg;
    logic [63:0] ctr_upper_next, ctr_lower_next;
    logic        wr_en;
    logic        en;
    logic        s_fire;
    logic [4:0]  nbytes;
    logic [127:0] key;

    logic        load_valid_reg;
    stage_t      load_reg;
    stage_t      load_next;

    logic        cell_valid [ROUNDS + 1];
    stage_t      cell_data [ROUNDS + 1];

    logic        out_valid_reg;
    logic [135:0] out_data_reg;
    logic [135:0] out_data_next;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[4:3])
            REG_KEY_HIGH: prdata = key_high_reg;
            REG_KEY_LOW:  prdata = key_low_reg;
            REG_CTR_HIGH: prdata = init_ctr_high_reg;
            REG_CTR_LOW:  prdata = init_ctr_low_reg;
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg <= '0;
            init_ctr_high_reg <= '0;
            init_ctr_low_reg <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[4:3])
                REG_KEY_HIGH: key_high_reg <= pwdata;
                REG_KEY_LOW:  key_low_reg <= pwdata;
                REG_CTR_HIGH: init_ctr_high_reg <= pwdata;
                REG_CTR_LOW:  init_ctr_low_reg <= pwdata;
                default:      ;
            endcase
        end
    end

    assign en = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign s_fire = s_axis_tvalid && en;
    assign nbytes = s_axis_tdata[132] ? FULL_BYTES : s_axis_tdata[132:128];
    assign key = {key_high_reg, key_low_reg};

    always_comb
    begin
        ctr_upper_next = s_axis_tuser ? init_ctr_high_reg : ctr_upper_reg;
        ctr_lower_next = s_axis_tuser ? init_ctr_low_reg : ctr_lower_reg;
        load_next.state = {ctr_upper_next, ctr_lower_next} ^ key;
        load_next.round_key = key;
        load_next.text = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
        load_next.nbytes = nbytes;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_upper_reg <= '0;
            ctr_lower_reg <= '0;
            load_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                ctr_upper_reg <= ctr_upper_next;
                ctr_lower_reg <= ctr_lower_next + {63'd0, nbytes == FULL_BYTES};
            end
            if (en)
            begin
                load_valid_reg <= s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            load_reg <= load_next;
        end
    end

    assign cell_valid[0] = load_valid_reg;
    assign cell_data[0] = load_reg;

    for (genvar i = 0; i < ROUNDS; i++)
    begin : g_round
        aesc_round_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .rcon       (RCON[i]),
            .last_round (i == ROUNDS - 1),
            .valid_in   (cell_valid[i]),
            .data_in    (cell_data[i]),
            .valid_out  (cell_valid[i + 1]),
            .data_out   (cell_data[i + 1])
        );
    end

    always_comb
    begin
        logic [127:0] res;
        res = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (5'(i) < cell_data[ROUNDS].nbytes)
            begin
                res[127 - 8 * i -: 8] = cell_data[ROUNDS].state[127 - 8 * i -: 8]
                    ^ cell_data[ROUNDS].text[127 - 8 * i -: 8];
            end
        end
        out_data_next = {3'd0, cell_data[ROUNDS].nbytes, res[63:0], res[127:64]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= cell_valid[ROUNDS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    `AESC_ASSERT_NEXT(a_ctr_step, s_fire && !s_axis_tuser && nbytes == FULL_BYTES, ctr_lower_reg == $past(ctr_lower_reg) + 64'd1)
    `AESC_ASSERT_NEXT(a_ctr_load, s_fire && s_axis_tuser && nbytes != FULL_BYTES, ctr_lower_reg == $past(init_ctr_low_reg) && ctr_upper_reg == $past(init_ctr_high_reg))
    `AESC_ASSERT_NOW(a_count_range, m_axis_tvalid, m_axis_tdata[132:128] <= FULL_BYTES)

endmodule

// File: sim/aes128_ctr_stream_cipher_tb.sv
// self-checking testbench for the aes128 counter mode stream cipher
`timescale 1ns / 100ps
module aes128_ctr_stream_cipher_tb
    import aesc_pkg::*;
();

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int PIPE_CYCLES = 12;
    localparam int RANDOM_BLOCKS = 1830;

    localparam logic [4:0] REG_KEY_HIGH = 5'd0;
    localparam logic [4:0] REG_KEY_LOW = 5'd8;
    localparam logic [4:0] REG_INIT_CTR_HIGH = 5'd16;
    localparam logic [4:0] REG_INIT_CTR_LOW = 5'd24;

    typedef struct packed {
        logic [63:0] text_high;
        logic [63:0] text_low;
        logic [4:0]  byte_count;
        logic        first_block;
    } block_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
        logic [4:0]  valid_bytes;
    } cipher_t;

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;

    block_t  pending_blocks[$];
    cipher_t expected_ciphers[$];

    logic [63:0] key_high_q, key_low_q, init_ctr_high_q, init_ctr_low_q;
    logic [63:0] ctr_upper_q, ctr_lower_q;

    int  errors;
    int  blocks_sent;
    int  ciphers_seen;
    int  idle_cycles;
    int  send_gap;
    int  recv_gap;
    bit  stim_done;
    bit  in_taken;

    aes128_ctr_stream_cipher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] gf_double(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] encrypt_block(input logic [127:0] key,
                                                   input logic [127:0] plain);
        logic [127:0] st, rk;
        logic [127:0] sh;
        logic [7:0] a0, a1, a2, a3, x, rc;
        logic [31:0] tw, w0, w1, w2, w3;
        rk = key;
        st = plain ^ rk;
        rc = 8'h01;
        for (int rnd = 1; rnd <= 10; rnd++)
        begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    sh[127 - 8 * (r + 4 * c) -: 8] =
                        SBOX[st[127 - 8 * (r + 4 * ((c + r) & 3)) -: 8]];
            if (rnd != 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = sh[127 - 32 * c -: 8];
                    a1 = sh[119 - 32 * c -: 8];
                    a2 = sh[111 - 32 * c -: 8];
                    a3 = sh[103 - 32 * c -: 8];
                    x = a0 ^ a1 ^ a2 ^ a3;
                    sh[127 - 32 * c -: 8] = a0 ^ x ^ gf_double(a0 ^ a1);
                    sh[119 - 32 * c -: 8] = a1 ^ x ^ gf_double(a1 ^ a2);
                    sh[111 - 32 * c -: 8] = a2 ^ x ^ gf_double(a2 ^ a3);
                    sh[103 - 32 * c -: 8] = a3 ^ x ^ gf_double(a3 ^ a0);
                end
            end
            tw = {SBOX[rk[23:16]] ^ rc, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
            w0 = rk[127:96] ^ tw;
            w1 = rk[95:64] ^ w0;
            w2 = rk[63:32] ^ w1;
            w3 = rk[31:0] ^ w2;
            rk = {w0, w1, w2, w3};
            rc = gf_double(rc);
            st = sh ^ rk;
        end
        return st;
    endfunction

    function automatic cipher_t ctr_mode_cipher(input block_t blk);
        cipher_t res;
        logic [127:0] keystream, txt, outv;
        int n;
        n = (blk.byte_count > 16) ? 16 : blk.byte_count;
        if (blk.first_block)
        begin
            ctr_upper_q = init_ctr_high_q;
            ctr_lower_q = init_ctr_low_q;
        end
        keystream = encrypt_block({key_high_q, key_low_q}, {ctr_upper_q, ctr_lower_q});
        txt = {blk.text_high, blk.text_low};
        outv = '0;
        for (int i = 0; i < 16; i++)
            if (i < n)
                outv[127 - 8 * i -: 8] = keystream[127 - 8 * i -: 8] ^ txt[127 - 8 * i -: 8];
        if (n == 16)
            ctr_lower_q = ctr_lower_q + 64'd1;
        res.cipher_high = outv[127:64];
        res.cipher_low = outv[63:0];
        res.valid_bytes = 5'(n);
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    task automatic queue_block(input logic [63:0] th, input logic [63:0] tl,
                               input logic [4:0] cnt, input logic first);
        block_t blk;
        blk.text_high = th;
        blk.text_low = tl;
        blk.byte_count = cnt;
        blk.first_block = first;
        pending_blocks.push_back(blk);
    endtask

    task automatic apb_write(input logic [4:0] addr, input logic [63:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            REG_KEY_HIGH:      key_high_q = data;
            REG_KEY_LOW:       key_low_q = data;
            REG_INIT_CTR_HIGH: init_ctr_high_q = data;
            default:           init_ctr_low_q = data;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_blocks.size() != 0 || expected_ciphers.size() != 0)
            @(posedge clk);
        repeat (PIPE_CYCLES + 4) @(posedge clk);
    endtask

    task automatic load_settings(input logic [63:0] kh, input logic [63:0] kl,
                                 input logic [63:0] ch, input logic [63:0] cl);
        wait_drained();
        apb_write(REG_KEY_HIGH, kh);
        apb_write(REG_KEY_LOW, kl);
        apb_write(REG_INIT_CTR_HIGH, ch);
        apb_write(REG_INIT_CTR_LOW, cl);
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && !in_taken)
            begin
            end
            else if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_blocks.size() != 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {3'b000, pending_blocks[0].byte_count,
                                 pending_blocks[0].text_low, pending_blocks[0].text_high};
                s_axis_tuser <= pending_blocks[0].first_block;
            end
            else
                s_axis_tvalid <= 1'b0;

            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // input acceptance and monitor
    always @(posedge clk)
    begin
        cipher_t got, want;
        block_t blk;
        if (rst_n)
        begin
            idle_cycles = idle_cycles + 1;
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                blk = pending_blocks.pop_front();
                expected_ciphers.push_back(ctr_mode_cipher(blk));
                blocks_sent <= blocks_sent + 1;
                idle_cycles = 0;
                if ($urandom_range(0, 3) == 0)
                    send_gap <= ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30)
                                                             : $urandom_range(1, 3);
                else
                    send_gap <= 0;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                idle_cycles = 0;
                ciphers_seen <= ciphers_seen + 1;
                got = cipher_t'({m_axis_tdata[63:0], m_axis_tdata[127:64],
                                 m_axis_tdata[132:128]});
                if (expected_ciphers.size() == 0)
                begin
                    $display("%0t: unexpected transaction expected none actual %h", $time, got);
                    errors = errors + 1;
                end
                else
                begin
                    want = expected_ciphers.pop_front();
                    if (got.cipher_high !== want.cipher_high)
                    begin
                        $display("%0t: cipher_high expected %h actual %h",
                                 $time, want.cipher_high, got.cipher_high);
                        errors = errors + 1;
                    end
                    if (got.cipher_low !== want.cipher_low)
                    begin
                        $display("%0t: cipher_low expected %h actual %h",
                                 $time, want.cipher_low, got.cipher_low);
                        errors = errors + 1;
                    end
                    if (got.valid_bytes !== want.valid_bytes)
                    begin
                        $display("%0t: valid_bytes expected %0d actual %0d",
                                 $time, want.valid_bytes, got.valid_bytes);
                        errors = errors + 1;
                    end
                end
            end
            if ($urandom_range(0, 4) == 0 && recv_gap == 0)
                recv_gap <= ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30)
                                                         : $urandom_range(1, 3);
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("timeout with %0d transactions outstanding", expected_ciphers.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        int cnt;
        int seg;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        errors = 0;
        blocks_sent = 0;
        ciphers_seen = 0;
        idle_cycles = 0;
        send_gap = 0;
        recv_gap = 0;
        stim_done = 0;
        in_taken = 0;
        key_high_q = '0;
        key_low_q = '0;
        init_ctr_high_q = '0;
        init_ctr_low_q = '0;
        ctr_upper_q = '0;
        ctr_lower_q = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings, then known test vector key
        queue_block('0, '0, 5'd16, 1'b0);
        queue_block('1, '1, 5'd16, 1'b0);
        load_settings(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
                      64'hf0f1f2f3f4f5f6f7, 64'hf8f9fafbfcfdfeff);
        queue_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1'b1);
        queue_block(64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 5'd16, 1'b0);
        queue_block('1, '1, 5'd1, 1'b0);
        queue_block('1, '1, 5'd15, 1'b0);
        queue_block('1, '1, 5'd0, 1'b0);
        queue_block('1, '1, 5'd17, 1'b0);
        queue_block('1, '1, 5'd31, 1'b0);
        queue_block(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd8, 1'b0);
        queue_block('0, '1, 5'd16, 1'b1);
        // counter wrap of the low half
        load_settings('1, '1, '1, 64'hfffffffffffffffe);
        for (int i = 0; i < 4; i++)
            queue_block(rand64(), rand64(), 5'd16, i == 0);
        queue_block('0, '0, 5'd16, 1'b1);

        for (int phase = 0; phase < 4; phase++)
        begin
            load_settings(rand64(), rand64(), rand64(),
                          (phase == 1) ? 64'hfffffffffffffff0 : rand64());
            for (int i = 0; i < RANDOM_BLOCKS / 4; )
            begin
                // mostly messages of full blocks ending in a partial one
                seg = $urandom_range(1, 12);
                for (int j = 0; j < seg; j++, i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        cnt = $urandom_range(0, 31);
                    else if (j == seg - 1)
                        cnt = $urandom_range(1, 16);
                    else
                        cnt = 16;
                    queue_block(rand64(), rand64(), 5'(cnt),
                                (j == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 19) == 0));
                end
                while (pending_blocks.size() > 32)
                    @(posedge clk);
            end
        end
        wait_drained();

        $display("%0d blocks sent, %0d checked, over the reset key, a known vector,",
                 blocks_sent, ciphers_seen);
        $display("a counter wrap and four random key and counter settings with stalls");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
